// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/tcprc_pkg.sv =====
// Shared types and constants of the congestion-window core.
// No dependencies.
package tcprc_pkg;

	localparam logic [15:0] SEG_RESET      = 16'd4000;
	localparam logic [15:0] INIT_TH_RESET  = 16'd512;
	localparam logic [15:0] TO_WIN_RESET   = 16'd256;
	localparam logic [6:0]  MAX_RETX_RESET = 7'd32;
	localparam logic [7:0]  DUP_LIMIT      = 8'd3;

	localparam logic [1:0] KIND_START   = 2'd0;
	localparam logic [1:0] KIND_ACK     = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	localparam logic [1:0] MODE_SS = 2'd0;
	localparam logic [1:0] MODE_CA = 2'd1;
	localparam logic [1:0] MODE_FR = 2'd2;

	localparam logic [2:0] REG_SEGMENT  = 3'd0;
	localparam logic [2:0] REG_INIT_TH  = 3'd1;
	localparam logic [2:0] REG_TO_WIN   = 3'd2;
	localparam logic [2:0] REG_TOTAL    = 3'd3;
	localparam logic [2:0] REG_MAX_RETX = 3'd4;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LATCH,
		OP_MUL_INIT,
		OP_START_SET,
		OP_DUP_INC,
		OP_DIV_CNT,
		OP_SAVE_CNT,
		OP_MODE_STEP,
		OP_MUL_SQ,
		OP_DIV_CA,
		OP_CA_APPLY,
		OP_MUL_CNT,
		OP_CNT_UPD,
		OP_MUL_BUSY,
		OP_DIV_SLOT,
		OP_SAVE_SLOT,
		OP_DIV_NEED,
		OP_SAVE_SEGS,
		OP_MUL_SEGS,
		OP_GRANT_UPD,
		OP_MUL_TO,
		OP_TO_SET,
		OP_PUBLISH
	} op_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       inflight_zero;
		logic       ack_eq;
		logic       ack_gt;
		logic       ca_grow;
		logic       grant_skip;
		logic       div_done;
		logic       out_free;
	} stat_t;

endpackage

// ===== hw/rtl/tcprc_div.sv =====
// Radix-2 restoring divider, 33-bit dividend by 32-bit divisor, 33 steps.
// No dependencies.
module tcprc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [32:0] quotient
);

	logic [32:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [5:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[32]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 6'd32;
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
			quo_q <= {quo_q[31:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/tcprc_datapath.sv =====
// Datapath: configuration, connection state, shared multiplier and divider, result word.
// Depends on tcprc_pkg and tcprc_div.
module tcprc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  tcprc_pkg::op_t    op,
	output tcprc_pkg::stat_t  stat,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic [1:0]        kind,
	input  logic [31:0]       ack_number,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        mode,
	output logic [31:0]       window_bytes,
	output logic [6:0]        resend_count,
	output logic [31:0]       resend_first_seq,
	output logic [31:0]       new_segments,
	output logic [31:0]       new_first_seq,
	output logic [31:0]       new_bytes,
	output logic              all_done
);

	localparam logic [31:0] WIN_RESET = 32'(tcprc_pkg::SEG_RESET);
	localparam logic [31:0] TH_RESET  =
		32'(tcprc_pkg::SEG_RESET) * 32'(tcprc_pkg::INIT_TH_RESET);

	function automatic logic [31:0] sat33(input logic [32:0] v);
		return v[32] ? '1 : v[31:0];
	endfunction

	logic [15:0] seg_q, init_q, towin_q;
	logic [31:0] total_q;
	logic [6:0]  maxr_q;

	logic [31:0] window_q, thresh_q, oldest_q, next_q, inflight_q, left_q;
	logic [1:0]  mode_q;
	logic [7:0]  dup_q;

	logic [1:0]  kind_q;
	logic [31:0] ack_q;
	logic [47:0] prod_q;
	logic [32:0] cnt_q, slots_q, segs_q;

	logic [6:0]  rcount_q;
	logic [31:0] rfirst_q, nseg_q, nfirst_q, nbytes_q;

	logic        outv_q;
	logic [1:0]  omode_q;
	logic [31:0] owin_q, orfirst_q, onseg_q, onfirst_q, onbytes_q;
	logic [6:0]  orcount_q;
	logic        odone_q;

	logic [15:0] s16;
	logic [31:0] s32;
	logic [32:0] s_m1;
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic        div_start;
	logic [32:0] div_dividend;
	logic [31:0] div_divisor;
	logic        div_done;
	logic [32:0] div_quo;

	logic [31:0] half_w, th_fr, w_fr, w_plus_s, ca_sum, ca_win, bytes, floor_w;
	logic [33:0] ca_wide;
	logic [6:0]  n_retx;

	assign s16  = (seg_q == '0) ? 16'd1 : seg_q;
	assign s32  = {16'b0, s16};
	assign s_m1 = {17'b0, s16} - 33'd1;

	always_comb begin
		mul_a = s32;
		mul_b = s16;
		case (op)
			tcprc_pkg::OP_MUL_INIT: mul_b = init_q;
			tcprc_pkg::OP_MUL_TO:   mul_b = towin_q;
			tcprc_pkg::OP_MUL_BUSY: mul_a = inflight_q;
			tcprc_pkg::OP_MUL_CNT:  mul_a = cnt_q[31:0];
			tcprc_pkg::OP_MUL_SEGS: mul_a = segs_q[31:0];
			default: ;
		endcase
	end

	always_comb begin
		div_start    = 1'b1;
		div_divisor  = s32;
		div_dividend = {1'b0, left_q} + s_m1;
		case (op)
			tcprc_pkg::OP_DIV_CNT:  div_dividend = {1'b0, 32'(ack_q - oldest_q)} + s_m1;
			tcprc_pkg::OP_DIV_SLOT: div_dividend = {1'b0, 32'(window_q - prod_q[31:0])} + s_m1;
			tcprc_pkg::OP_DIV_NEED: div_dividend = {1'b0, left_q} + s_m1;
			tcprc_pkg::OP_DIV_CA: begin
				div_dividend = {1'b0, prod_q[31:0]};
				div_divisor  = (window_q == '0) ? 32'd1 : window_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	tcprc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign half_w   = window_q >> 1;
	assign th_fr    = (half_w > s32) ? half_w : s32;
	assign w_fr     = sat33({1'b0, th_fr} + {15'b0, {2'b0, s16} + {1'b0, s16, 1'b0}});
	assign w_plus_s = sat33({1'b0, window_q} + {17'b0, s16});
	assign ca_wide  = {2'b0, window_q} + {1'b0, div_quo};
	assign ca_sum   = (ca_wide[33:32] != 2'b0) ? '1 : ca_wide[31:0];
	assign ca_win   = (ca_sum > s32) ? ca_sum : s32;
	assign bytes    = (prod_q > {16'b0, left_q}) ? left_q : prod_q[31:0];
	assign floor_w  = prod_q[31:0];
	assign n_retx   = (inflight_q < {25'b0, maxr_q}) ? inflight_q[6:0] : maxr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q      <= tcprc_pkg::SEG_RESET;
			init_q     <= tcprc_pkg::INIT_TH_RESET;
			towin_q    <= tcprc_pkg::TO_WIN_RESET;
			total_q    <= '0;
			maxr_q     <= tcprc_pkg::MAX_RETX_RESET;
			window_q   <= WIN_RESET;
			thresh_q   <= TH_RESET;
			mode_q     <= tcprc_pkg::MODE_SS;
			dup_q      <= '0;
			oldest_q   <= '0;
			next_q     <= '0;
			inflight_q <= '0;
			left_q     <= '0;
			outv_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					tcprc_pkg::REG_SEGMENT:  seg_q   <= cfg_data[15:0];
					tcprc_pkg::REG_INIT_TH:  init_q  <= cfg_data[15:0];
					tcprc_pkg::REG_TO_WIN:   towin_q <= cfg_data[15:0];
					tcprc_pkg::REG_TOTAL:    total_q <= cfg_data;
					tcprc_pkg::REG_MAX_RETX: maxr_q  <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (op == tcprc_pkg::OP_PUBLISH)
				outv_q <= 1'b1;
			else if (outv_q && !out_stall)
				outv_q <= 1'b0;
			case (op)
				tcprc_pkg::OP_START_SET: begin
					window_q   <= s32;
					thresh_q   <= prod_q[31:0];
					mode_q     <= tcprc_pkg::MODE_SS;
					dup_q      <= '0;
					oldest_q   <= '0;
					next_q     <= '0;
					inflight_q <= '0;
					left_q     <= total_q;
				end
				tcprc_pkg::OP_DUP_INC: begin
					if (dup_q != 8'hFF)
						dup_q <= dup_q + 8'd1;
				end
				tcprc_pkg::OP_DIV_CNT: dup_q <= '0;
				tcprc_pkg::OP_MODE_STEP: begin
					if (mode_q != tcprc_pkg::MODE_FR && dup_q >= tcprc_pkg::DUP_LIMIT) begin
						mode_q   <= tcprc_pkg::MODE_FR;
						thresh_q <= th_fr;
						window_q <= w_fr;
						dup_q    <= '0;
					end else if (mode_q == tcprc_pkg::MODE_SS && dup_q == '0) begin
						if (window_q >= thresh_q)
							mode_q <= tcprc_pkg::MODE_CA;
						else
							window_q <= w_plus_s;
					end else if (mode_q == tcprc_pkg::MODE_FR) begin
						if (dup_q != '0) begin
							window_q <= w_plus_s;
						end else begin
							window_q <= (thresh_q > s32) ? thresh_q : s32;
							mode_q   <= tcprc_pkg::MODE_CA;
						end
					end
				end
				tcprc_pkg::OP_CA_APPLY: window_q <= ca_win;
				tcprc_pkg::OP_CNT_UPD: begin
					if (cnt_q >= {1'b0, inflight_q}) begin
						inflight_q <= '0;
						oldest_q   <= next_q;
					end else begin
						inflight_q <= inflight_q - cnt_q[31:0];
						oldest_q   <= oldest_q + prod_q[31:0];
					end
				end
				tcprc_pkg::OP_GRANT_UPD: begin
					next_q     <= next_q + bytes;
					left_q     <= left_q - bytes;
					inflight_q <= sat33({1'b0, inflight_q} + segs_q);
				end
				tcprc_pkg::OP_TO_SET: begin
					mode_q   <= tcprc_pkg::MODE_SS;
					thresh_q <= (half_w > floor_w) ? half_w : floor_w;
					window_q <= floor_w;
					dup_q    <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			tcprc_pkg::OP_LATCH: begin
				kind_q   <= kind;
				ack_q    <= ack_number;
				rcount_q <= '0;
				rfirst_q <= '0;
				nseg_q   <= '0;
				nfirst_q <= '0;
				nbytes_q <= '0;
			end
			tcprc_pkg::OP_MUL_INIT, tcprc_pkg::OP_MUL_SQ, tcprc_pkg::OP_MUL_CNT,
			tcprc_pkg::OP_MUL_BUSY, tcprc_pkg::OP_MUL_SEGS, tcprc_pkg::OP_MUL_TO:
				prod_q <= mul_a * mul_b;
			tcprc_pkg::OP_SAVE_CNT:  cnt_q   <= div_quo;
			tcprc_pkg::OP_SAVE_SLOT: slots_q <= div_quo;
			tcprc_pkg::OP_SAVE_SEGS: segs_q  <= (slots_q < div_quo) ? slots_q : div_quo;
			tcprc_pkg::OP_MODE_STEP: begin
				if (mode_q != tcprc_pkg::MODE_FR && dup_q >= tcprc_pkg::DUP_LIMIT) begin
					rcount_q <= 7'd1;
					rfirst_q <= oldest_q;
				end
			end
			tcprc_pkg::OP_GRANT_UPD: begin
				nseg_q   <= segs_q[31:0];
				nfirst_q <= next_q;
				nbytes_q <= bytes;
			end
			tcprc_pkg::OP_TO_SET: begin
				rcount_q <= n_retx;
				rfirst_q <= (n_retx != '0) ? oldest_q : '0;
			end
			tcprc_pkg::OP_PUBLISH: begin
				omode_q   <= mode_q;
				owin_q    <= window_q;
				orcount_q <= rcount_q;
				orfirst_q <= rfirst_q;
				onseg_q   <= nseg_q;
				onfirst_q <= nfirst_q;
				onbytes_q <= nbytes_q;
				odone_q   <= (left_q == '0) && (inflight_q == '0);
			end
			default: ;
		endcase
	end

	assign stat.kind          = kind_q;
	assign stat.inflight_zero = inflight_q == '0;
	assign stat.ack_eq        = ack_q == oldest_q;
	assign stat.ack_gt        = ack_q > oldest_q;
	assign stat.ca_grow       = (mode_q == tcprc_pkg::MODE_CA) && (dup_q == '0);
	assign stat.grant_skip    = (left_q == '0) || ({16'b0, window_q} <= prod_q);
	assign stat.div_done      = div_done;
	assign stat.out_free      = !outv_q || !out_stall;

	assign out_valid        = outv_q;
	assign mode             = omode_q;
	assign window_bytes     = owin_q;
	assign resend_count     = orcount_q;
	assign resend_first_seq = orfirst_q;
	assign new_segments     = onseg_q;
	assign new_first_seq    = onfirst_q;
	assign new_bytes        = onbytes_q;
	assign all_done         = odone_q;

endmodule

// ===== hw/rtl/tcprc_ctrl.sv =====
// Controller: sequences start, acknowledgement, timeout and grant steps.
// Depends on tcprc_pkg.
module tcprc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  tcprc_pkg::stat_t stat,
	output tcprc_pkg::op_t   op
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISPATCH, ST_START_MUL, ST_START_SET, ST_DUP, ST_CNT_DIV,
		ST_CNT_WAIT, ST_MODE, ST_CA_DIV, ST_CA_WAIT, ST_CNT_MUL, ST_CNT_UPD,
		ST_GRANT_MUL, ST_GRANT_CHK, ST_SLOT_WAIT, ST_NEED_DIV, ST_NEED_WAIT,
		ST_BYTES_MUL, ST_GRANT_UPD, ST_TO_MUL, ST_TO_SET, ST_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   newack_q, newack_d;

	always_comb begin
		state_d  = state_q;
		newack_d = newack_q;
		op       = tcprc_pkg::OP_NOP;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op      = tcprc_pkg::OP_LATCH;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_d = ST_FINISH;
				unique case (stat.kind)
					tcprc_pkg::KIND_START: state_d = ST_START_MUL;
					tcprc_pkg::KIND_ACK: begin
						if (!stat.inflight_zero && stat.ack_eq) begin
							newack_d = 1'b0;
							state_d  = ST_DUP;
						end else if (!stat.inflight_zero && stat.ack_gt) begin
							newack_d = 1'b1;
							state_d  = ST_CNT_DIV;
						end
					end
					tcprc_pkg::KIND_TIMEOUT: begin
						if (!stat.inflight_zero)
							state_d = ST_TO_MUL;
					end
					default: ;
				endcase
			end
			ST_START_MUL: begin
				op      = tcprc_pkg::OP_MUL_INIT;
				state_d = ST_START_SET;
			end
			ST_START_SET: begin
				op      = tcprc_pkg::OP_START_SET;
				state_d = ST_GRANT_MUL;
			end
			ST_DUP: begin
				op      = tcprc_pkg::OP_DUP_INC;
				state_d = ST_MODE;
			end
			ST_CNT_DIV: begin
				op      = tcprc_pkg::OP_DIV_CNT;
				state_d = ST_CNT_WAIT;
			end
			ST_CNT_WAIT: begin
				if (stat.div_done) begin
					op      = tcprc_pkg::OP_SAVE_CNT;
					state_d = ST_MODE;
				end
			end
			ST_MODE: begin
				if (stat.ca_grow) begin
					op      = tcprc_pkg::OP_MUL_SQ;
					state_d = ST_CA_DIV;
				end else begin
					op      = tcprc_pkg::OP_MODE_STEP;
					state_d = newack_q ? ST_CNT_MUL : ST_FINISH;
				end
			end
			ST_CA_DIV: begin
				op      = tcprc_pkg::OP_DIV_CA;
				state_d = ST_CA_WAIT;
			end
			ST_CA_WAIT: begin
				if (stat.div_done) begin
					op      = tcprc_pkg::OP_CA_APPLY;
					state_d = newack_q ? ST_CNT_MUL : ST_FINISH;
				end
			end
			ST_CNT_MUL: begin
				op      = tcprc_pkg::OP_MUL_CNT;
				state_d = ST_CNT_UPD;
			end
			ST_CNT_UPD: begin
				op      = tcprc_pkg::OP_CNT_UPD;
				state_d = ST_GRANT_MUL;
			end
			ST_GRANT_MUL: begin
				op      = tcprc_pkg::OP_MUL_BUSY;
				state_d = ST_GRANT_CHK;
			end
			ST_GRANT_CHK: begin
				if (stat.grant_skip) begin
					state_d = ST_FINISH;
				end else begin
					op      = tcprc_pkg::OP_DIV_SLOT;
					state_d = ST_SLOT_WAIT;
				end
			end
			ST_SLOT_WAIT: begin
				if (stat.div_done) begin
					op      = tcprc_pkg::OP_SAVE_SLOT;
					state_d = ST_NEED_DIV;
				end
			end
			ST_NEED_DIV: begin
				op      = tcprc_pkg::OP_DIV_NEED;
				state_d = ST_NEED_WAIT;
			end
			ST_NEED_WAIT: begin
				if (stat.div_done) begin
					op      = tcprc_pkg::OP_SAVE_SEGS;
					state_d = ST_BYTES_MUL;
				end
			end
			ST_BYTES_MUL: begin
				op      = tcprc_pkg::OP_MUL_SEGS;
				state_d = ST_GRANT_UPD;
			end
			ST_GRANT_UPD: begin
				op      = tcprc_pkg::OP_GRANT_UPD;
				state_d = ST_FINISH;
			end
			ST_TO_MUL: begin
				op      = tcprc_pkg::OP_MUL_TO;
				state_d = ST_TO_SET;
			end
			ST_TO_SET: begin
				op      = tcprc_pkg::OP_TO_SET;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					op      = tcprc_pkg::OP_PUBLISH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			newack_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			newack_q <= newack_d;
		end
	end

	assign in_stall = state_q != ST_IDLE;

endmodule

// ===== hw/rtl/tcp_reno_congestion_window_core.sv =====
// Top level of the congestion-window core: controller plus datapath.
// Depends on tcprc_pkg, tcprc_ctrl, tcprc_datapath.
//
// One word in, one word out. Starts with something to grant and new
// acknowledgements wait on the shared radix-2 divider, used for the acked
// segment count, the avoidance increase and the two grant quotients; a word
// that changes nothing, a timeout or a duplicate acknowledgement does not
// use it. The input reopens on the cycle after the result is loaded; a
// waiting result holds the next one. The result register lets the next word
// in while a result waits. Configuration writes are always ready and take
// effect at once.
module tcp_reno_congestion_window_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] ack_number,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  mode,
	output logic [31:0] window_bytes,
	output logic [6:0]  resend_count,
	output logic [31:0] resend_first_seq,
	output logic [31:0] new_segments,
	output logic [31:0] new_first_seq,
	output logic [31:0] new_bytes,
	output logic        all_done
);

	tcprc_pkg::op_t   op;
	tcprc_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	tcprc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.op       (op)
	);

	tcprc_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.op               (op),
		.stat             (stat),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.kind             (kind),
		.ack_number       (ack_number),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.mode             (mode),
		.window_bytes     (window_bytes),
		.resend_count     (resend_count),
		.resend_first_seq (resend_first_seq),
		.new_segments     (new_segments),
		.new_first_seq    (new_first_seq),
		.new_bytes        (new_bytes),
		.all_done         (all_done)
	);

endmodule

// ===== hw/rtl/tcprc_checker.sv =====
// Port-level checker for the congestion-window core, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tcprc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [31:0] cfg_data,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  kind,
	input logic [31:0] ack_number,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  mode,
	input logic [31:0] window_bytes,
	input logic [6:0]  resend_count,
	input logic [31:0] resend_first_seq,
	input logic [31:0] new_segments,
	input logic [31:0] new_first_seq,
	input logic [31:0] new_bytes,
	input logic        all_done
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(window_bytes))
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`ASSERT_IMPLIES(a_no_grant_no_bytes, clk, arst_n, out_valid && new_segments == 32'd0, new_bytes == 32'd0 && new_first_seq == 32'd0)
	`ASSERT_IMPLIES(a_no_resend_no_seq, clk, arst_n, out_valid && resend_count == 7'd0, resend_first_seq == 32'd0)

endmodule

bind tcp_reno_congestion_window_core tcprc_checker u_chk (.*);
